@@ hdl/pdfm_pkg.sv @@
`timescale 1ns / 1ps

package pdfm_pkg;

   localparam int CHANNELS  = 8;
   localparam int TICK_BITS = 24;

   localparam int CH_AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CHAN_W    = 3;
   localparam int TICK_W    = 24;
   localparam int DUTY_W    = 16;
   localparam int FREQ_W    = 32;
   localparam int ERR_W     = 8;
   localparam int SCALE_W   = 16;
   localparam int TLEN_W    = 8;
   localparam int PROD_W    = TICK_W + SCALE_W;
   localparam int FDIV_W    = TICK_W + TLEN_W;
   localparam int STEP_W    = $clog2(FREQ_W);
   localparam int CSR_W     = 32;
   localparam int CSR_IDX_W = 3;
   localparam int OUTC_W    = 2;

   localparam logic [TICK_W-1:0] TICK_MASK = (TICK_BITS >= TICK_W) ? {TICK_W{1'b1}} :
                                             TICK_W'((64'd1 << TICK_BITS) - 64'd1);

   localparam logic [DUTY_W-1:0] INVALID_DUTY = {DUTY_W{1'b1}};
   localparam logic [FREQ_W-1:0] INVALID_FREQ = {FREQ_W{1'b1}};
   localparam logic [ERR_W-1:0]  ERR_MAX      = {ERR_W{1'b1}};

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PERIOD      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PERIOD      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_SCALE      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FREQ_NUMERATOR  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_LENGTH     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ERROR_THRESHOLD = 3'd5;

   localparam logic [OUTC_W-1:0] OUTC_MEASURED    = 2'd0;
   localparam logic [OUTC_W-1:0] OUTC_HELD        = 2'd1;
   localparam logic [OUTC_W-1:0] OUTC_INVALIDATED = 2'd2;
   localparam logic [OUTC_W-1:0] OUTC_ZERO        = 2'd3;

   localparam logic [TICK_W-1:0]  RST_MIN_PERIOD      = 24'd1;
   localparam logic [TICK_W-1:0]  RST_MAX_PERIOD      = 24'd16777215;
   localparam logic [SCALE_W-1:0] RST_DUTY_SCALE      = 16'd10000;
   localparam logic [FREQ_W-1:0]  RST_FREQ_NUMERATOR  = 32'd100000000;
   localparam logic [TLEN_W-1:0]  RST_TICK_LENGTH     = 8'd1;
   localparam logic [ERR_W-1:0]   RST_ERROR_THRESHOLD = 8'd3;

   typedef struct packed {
      logic              level;
      logic [DUTY_W-1:0] duty;
      logic [FREQ_W-1:0] freq;
      logic [ERR_W-1:0]  err;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

@@ hdl/pdfm_ram.sv @@
`timescale 1ns / 1ps

module pdfm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/pdfm_calc.sv @@
`timescale 1ns / 1ps

module pdfm_calc (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [pdfm_pkg::TICK_W-1:0]    active,
   input  logic [pdfm_pkg::TICK_W-1:0]    period,
   input  logic [pdfm_pkg::SCALE_W-1:0]   duty_scale,
   input  logic [pdfm_pkg::FREQ_W-1:0]    freq_numerator,
   input  logic [pdfm_pkg::TLEN_W-1:0]    tick_length,
   output logic                           done,
   output logic [pdfm_pkg::DUTY_W-1:0]    duty,
   output logic [pdfm_pkg::FREQ_W-1:0]    freq
);

   import pdfm_pkg::*;

   typedef enum logic [2:0] {C_IDLE, C_MUL, C_INIT, C_DIV, C_DONE} calc_state_type;

   calc_state_type      state_ff, state_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [FDIV_W-1:0]   fdiv_ff, fdiv_in;
   logic                sat_ff, sat_in;
   logic [TICK_W-1:0]   drem_ff, drem_in;
   logic [DUTY_W-1:0]   dq_ff, dq_in;
   logic [FREQ_W-1:0]   frem_ff, frem_in;
   logic [FREQ_W-1:0]   fq_ff, fq_in;
   logic [STEP_W-1:0]   cnt_ff, cnt_in;

   logic [TICK_W:0]     dt;
   logic                dge;
   logic [FREQ_W:0]     ft;
   logic                fge;

   // restoring division, one quotient bit per cycle on each side
   assign dt  = {drem_ff, dq_ff[DUTY_W-1]};
   assign dge = dt >= {1'b0, period};
   assign ft  = {frem_ff, fq_ff[FREQ_W-1]};
   assign fge = ft >= {1'b0, fdiv_ff};

   always_comb begin
      state_in = state_ff;
      prod_in  = prod_ff;
      fdiv_in  = fdiv_ff;
      sat_in   = sat_ff;
      drem_in  = drem_ff;
      dq_in    = dq_ff;
      frem_in  = frem_ff;
      fq_in    = fq_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         C_IDLE: begin
            if (start) begin
               state_in = C_MUL;
            end
         end
         C_MUL: begin
            prod_in  = PROD_W'(active) * PROD_W'(duty_scale);
            fdiv_in  = FDIV_W'(period) * FDIV_W'(tick_length);
            state_in = C_INIT;
         end
         C_INIT: begin
            // quotient >= 2^16 exactly when the upper product bits reach the period
            sat_in   = prod_ff[PROD_W-1:DUTY_W] >= period;
            drem_in  = prod_ff[PROD_W-1:DUTY_W];
            dq_in    = prod_ff[DUTY_W-1:0];
            frem_in  = '0;
            fq_in    = freq_numerator;
            cnt_in   = '0;
            state_in = C_DIV;
         end
         C_DIV: begin
            if (cnt_ff < STEP_W'(DUTY_W)) begin
               drem_in = dge ? TICK_W'(dt - {1'b0, period}) : dt[TICK_W-1:0];
               dq_in   = {dq_ff[DUTY_W-2:0], dge};
            end
            frem_in = fge ? FREQ_W'(ft - {1'b0, fdiv_ff}) : ft[FREQ_W-1:0];
            fq_in   = {fq_ff[FREQ_W-2:0], fge};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == STEP_W'(FREQ_W - 1)) begin
               state_in = C_DONE;
            end
         end
         C_DONE: begin
            state_in = C_IDLE;
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
      end else begin
         state_ff <= state_in;
      end
      prod_ff <= prod_in;
      fdiv_ff <= fdiv_in;
      sat_ff  <= sat_in;
      drem_ff <= drem_in;
      dq_ff   <= dq_in;
      frem_ff <= frem_in;
      fq_ff   <= fq_in;
      cnt_ff  <= cnt_in;
   end

   assign done = (state_ff == C_DONE);
   assign duty = sat_ff ? INVALID_DUTY : dq_ff;
   assign freq = fq_ff;

endmodule

@@ hdl/pwm_duty_frequency_monitor.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Transfer when          Payload
// req_*     in   req_valid & req_ready  channel, input_level, active_ticks, period_ticks
// rsp_*     out  rsp_valid & rsp_ready  out_channel, level_now, duty, freq, bad_count, outcome
// csr_*     in   csr_we                 csr_index, csr_wdata
//
// One item at a time. An in-range period goes from one transfer to the next through
// table read, product, 32-step shared division loop, write-back.
// Zero, bad and ignored captures skip the division and go from table read to write-back.
// Per-channel state sits in an 8-entry RAM with valid flops; reset clears the flops.
// A result waiting on rsp_ready stalls only the write-back of the next item.

module pwm_duty_frequency_monitor (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [pdfm_pkg::CHAN_W-1:0]       req_channel,
   input  logic                              req_input_level,
   input  logic [pdfm_pkg::TICK_W-1:0]       req_active_ticks,
   input  logic [pdfm_pkg::TICK_W-1:0]       req_period_ticks,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [pdfm_pkg::CHAN_W-1:0]       rsp_out_channel,
   output logic                              rsp_level_now,
   output logic [pdfm_pkg::DUTY_W-1:0]       rsp_duty_centi_pct,
   output logic [pdfm_pkg::FREQ_W-1:0]       rsp_freq_centi_hz,
   output logic [pdfm_pkg::ERR_W-1:0]        rsp_bad_count,
   output logic [pdfm_pkg::OUTC_W-1:0]       rsp_outcome,
   input  logic                              csr_we,
   input  logic [pdfm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pdfm_pkg::CSR_W-1:0]        csr_wdata
);

   import pdfm_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_CALC, ST_FINISH} state_type;

   logic [TICK_W-1:0]  min_period_ff, min_period_in;
   logic [TICK_W-1:0]  max_period_ff, max_period_in;
   logic [SCALE_W-1:0] duty_scale_ff, duty_scale_in;
   logic [FREQ_W-1:0]  freq_num_ff, freq_num_in;
   logic [TLEN_W-1:0]  tick_len_ff, tick_len_in;
   logic [ERR_W-1:0]   err_thr_ff, err_thr_in;

   state_type          state_ff, state_in;
   logic [CHAN_W-1:0]  ch_ff, ch_in;
   logic               level_ff, level_in;
   logic [TICK_W-1:0]  active_ff, active_in;
   logic [TICK_W-1:0]  period_ff, period_in;
   entry_type          entry_ff, entry_in;
   logic [OUTC_W-1:0]  outc_ff, outc_in;
   logic               wr_ff, wr_in;
   logic [CHANNELS-1:0] vld_ff, vld_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [CHAN_W-1:0]  rsp_ch_ff, rsp_ch_in;
   entry_type          rsp_entry_ff, rsp_entry_in;
   logic [OUTC_W-1:0]  rsp_outc_ff, rsp_outc_in;

   logic [CH_AW-1:0]   addr;
   logic               ch_ok;
   logic [ENTRY_W-1:0] ram_rdata;
   entry_type          cur_entry;
   logic [ERR_W-1:0]   err_inc;
   logic               ram_we;
   logic               ram_re;
   logic               calc_start;
   logic               calc_done;
   logic [DUTY_W-1:0]  calc_duty;
   logic [FREQ_W-1:0]  calc_freq;

   // register file
   always_comb begin
      min_period_in = min_period_ff;
      max_period_in = max_period_ff;
      duty_scale_in = duty_scale_ff;
      freq_num_in   = freq_num_ff;
      tick_len_in   = tick_len_ff;
      err_thr_in    = err_thr_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MIN_PERIOD:      min_period_in = csr_wdata[TICK_W-1:0];
            CSR_MAX_PERIOD:      max_period_in = csr_wdata[TICK_W-1:0];
            CSR_DUTY_SCALE:      duty_scale_in = csr_wdata[SCALE_W-1:0];
            CSR_FREQ_NUMERATOR:  freq_num_in   = csr_wdata[FREQ_W-1:0];
            CSR_TICK_LENGTH:     tick_len_in   = csr_wdata[TLEN_W-1:0];
            CSR_ERROR_THRESHOLD: err_thr_in    = csr_wdata[ERR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_period_ff <= RST_MIN_PERIOD;
         max_period_ff <= RST_MAX_PERIOD;
         duty_scale_ff <= RST_DUTY_SCALE;
         freq_num_ff   <= RST_FREQ_NUMERATOR;
         tick_len_ff   <= RST_TICK_LENGTH;
         err_thr_ff    <= RST_ERROR_THRESHOLD;
      end else begin
         min_period_ff <= min_period_in;
         max_period_ff <= max_period_in;
         duty_scale_ff <= duty_scale_in;
         freq_num_ff   <= freq_num_in;
         tick_len_ff   <= tick_len_in;
         err_thr_ff    <= err_thr_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign ram_re    = req_valid && req_ready;
   assign addr      = CH_AW'(ch_ff);
   assign ch_ok     = 32'(ch_ff) < 32'(CHANNELS);
   // unwritten entries read as the reset value
   assign cur_entry = vld_ff[addr] ? entry_type'(ram_rdata) : '0;
   assign err_inc   = (cur_entry.err == ERR_MAX) ? ERR_MAX : cur_entry.err + 1'b1;

   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      level_in     = level_ff;
      active_in    = active_ff;
      period_in    = period_ff;
      entry_in     = entry_ff;
      outc_in      = outc_ff;
      wr_in        = wr_ff;
      vld_in       = vld_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_ch_in    = rsp_ch_ff;
      rsp_entry_in = rsp_entry_ff;
      rsp_outc_in  = rsp_outc_ff;
      calc_start   = 1'b0;
      ram_we       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ch_in     = req_channel;
               level_in  = req_input_level;
               active_in = req_active_ticks & TICK_MASK;
               period_in = req_period_ticks & TICK_MASK;
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            entry_in       = cur_entry;
            entry_in.level = level_ff;
            wr_in          = 1'b1;
            outc_in        = OUTC_ZERO;
            state_in       = ST_FINISH;
            if (!ch_ok) begin
               entry_in = '0;
               wr_in    = 1'b0;
            end else if (period_ff == '0) begin
               // level only
            end else if (period_ff >= min_period_ff && period_ff <= max_period_ff) begin
               calc_start = 1'b1;
               state_in   = ST_CALC;
            end else begin
               entry_in.err = err_inc;
               if (err_inc >= err_thr_ff) begin
                  entry_in.duty = INVALID_DUTY;
                  entry_in.freq = INVALID_FREQ;
                  outc_in       = OUTC_INVALIDATED;
               end else begin
                  outc_in = OUTC_HELD;
               end
            end
         end
         ST_CALC: begin
            if (calc_done) begin
               entry_in.duty = calc_duty;
               entry_in.freq = calc_freq;
               entry_in.err  = '0;
               outc_in       = OUTC_MEASURED;
               state_in      = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_ch_in    = ch_ff;
               rsp_entry_in = entry_ff;
               rsp_outc_in  = outc_ff;
               ram_we       = wr_ff;
               if (wr_ff) begin
                  vld_in[addr] = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ch_ff        <= ch_in;
      level_ff     <= level_in;
      active_ff    <= active_in;
      period_ff    <= period_in;
      entry_ff     <= entry_in;
      outc_ff      <= outc_in;
      wr_ff        <= wr_in;
      rsp_ch_ff    <= rsp_ch_in;
      rsp_entry_ff <= rsp_entry_in;
      rsp_outc_ff  <= rsp_outc_in;
   end

   pdfm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CHANNELS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (addr),
      .wr_data (entry_ff),
      .rd_en   (ram_re),
      .rd_addr (CH_AW'(req_channel)),
      .rd_data (ram_rdata)
   );

   pdfm_calc u_calc (
      .clock          (clock),
      .reset          (reset),
      .start          (calc_start),
      .active         (active_ff),
      .period         (period_ff),
      .duty_scale     (duty_scale_ff),
      .freq_numerator (freq_num_ff),
      .tick_length    (tick_len_ff),
      .done           (calc_done),
      .duty           (calc_duty),
      .freq           (calc_freq)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_channel    = rsp_ch_ff;
   assign rsp_level_now      = rsp_entry_ff.level;
   assign rsp_duty_centi_pct = rsp_entry_ff.duty;
   assign rsp_freq_centi_hz  = rsp_entry_ff.freq;
   assign rsp_bad_count      = rsp_entry_ff.err;
   assign rsp_outcome        = rsp_outc_ff;

endmodule

@@ hdl/pdfm_checker.sv @@
`timescale 1ns / 1ps

module pdfm_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [pdfm_pkg::CHAN_W-1:0]       rsp_out_channel,
   input  logic                              rsp_level_now,
   input  logic [pdfm_pkg::DUTY_W-1:0]       rsp_duty_centi_pct,
   input  logic [pdfm_pkg::FREQ_W-1:0]       rsp_freq_centi_hz,
   input  logic [pdfm_pkg::ERR_W-1:0]        rsp_bad_count,
   input  logic [pdfm_pkg::OUTC_W-1:0]       rsp_outcome
);

   import pdfm_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_channel)
         && $stable(rsp_level_now)
         && $stable(rsp_duty_centi_pct) && $stable(rsp_freq_centi_hz)
         && $stable(rsp_bad_count) && $stable(rsp_outcome))
      else $error("result changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second transfer taken while busy");

   a_measured_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outcome == OUTC_MEASURED |-> rsp_bad_count == '0)
      else $error("measured result with nonzero error count");

   a_invalid_marks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outcome == OUTC_INVALIDATED |->
         rsp_duty_centi_pct == INVALID_DUTY && rsp_freq_centi_hz == INVALID_FREQ
         && rsp_bad_count != '0)
      else $error("invalidated result without markers");

   a_held_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outcome == OUTC_HELD |-> rsp_bad_count != '0)
      else $error("held result with zero error count");

endmodule

bind pwm_duty_frequency_monitor pdfm_checker u_pdfm_checker (.*);
